FILE: src/bonded_pair_spring_damper_force_core_defines.svh
// Assertion macros used by the checker file of the bonded pair force core.
// Depends on nothing; the including scope must provide clk and arst_n.
`ifndef BONDED_PAIR_SPRING_DAMPER_FORCE_CORE_DEFINES_SVH
`define BONDED_PAIR_SPRING_DAMPER_FORCE_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is active.
`define BPSD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, masked while reset is active.
`define BPSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/bpsd_pkg.sv
// Shared types and constants of the bonded pair force core.
// Depends on nothing; imported by the sqrt and divide pipelines and the top level.
package bpsd_pkg;

	localparam int DW    = 33;  // width of a coordinate difference
	localparam int RADW  = 66;  // width of the squared distance
	localparam int ROOTW = 34;  // width of the distance
	localparam int QW    = 31;  // width of a normal component magnitude
	localparam int AW    = 4;   // APB address width

	typedef logic [DW-1:0]    dmag_t;
	typedef logic [RADW-1:0]  rad_t;
	typedef logic [ROOTW-1:0] root_t;
	typedef logic [QW-1:0]    quo_t;

	typedef enum logic [AW-1:0] {
		ADDR_STIFF = 4'h0,
		ADDR_DAMP  = 4'h4,
		ADDR_REST  = 4'h8
	} reg_addr_t;

	typedef struct packed {
		logic [2:0]           neg;   // sign of each separation component
		logic signed [DW-1:0] dv_x;
		logic signed [DW-1:0] dv_y;
		logic signed [DW-1:0] dv_z;
		logic                 zero;  // centers coincide
	} geom_t;

	typedef struct packed {
		geom_t       g;
		dmag_t [2:0] mag;
	} sqrt_side_t;

	typedef struct packed {
		geom_t g;
		root_t sep_len;
	} div_side_t;

endpackage

FILE: src/bpsd_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on bpsd_pkg.
module bpsd_sqrt import bpsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       in_valid,
	input  rad_t       rad,
	input  sqrt_side_t in_side,
	output logic       out_valid,
	output root_t      root,
	output sqrt_side_t out_side
);
	localparam int NS = ROOTW;
	localparam int RW = ROOTW + 4;
	localparam int PW = 2 * NS;

	logic [NS-1:0] v_s;
	logic [RW-1:0] r_s    [NS];
	root_t         q_s    [NS];
	logic [PW-1:0] rad_s  [NS];
	sqrt_side_t    side_s [NS];

	for (genvar j = 0; j < NS; j++) begin : g_stage
		logic [RW-1:0] r_i, rr, t;
		root_t         q_i;
		logic [PW-1:0] rad_i;
		sqrt_side_t    side_i;
		logic          v_i, ge;

		if (j == 0) begin : g_first
			assign r_i    = '0;
			assign q_i    = '0;
			assign rad_i  = {{(PW-RADW){1'b0}}, rad};
			assign side_i = in_side;
			assign v_i    = in_valid;
		end else begin : g_next
			assign r_i    = r_s[j-1];
			assign q_i    = q_s[j-1];
			assign rad_i  = rad_s[j-1];
			assign side_i = side_s[j-1];
			assign v_i    = v_s[j-1];
		end

		// bring down the next two radicand bits and try root*4+1
		assign rr = {r_i[RW-3:0], rad_i[2*(NS-1-j)+1 -: 2]};
		assign t  = {{(RW-ROOTW-2){1'b0}}, q_i, 2'b01};
		assign ge = (rr >= t);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[j] <= 1'b0;
			else if (en) v_s[j] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[j]    <= ge ? rr - t : rr;
				q_s[j]    <= {q_i[ROOTW-2:0], ge};
				rad_s[j]  <= rad_i;
				side_s[j] <= side_i;
			end
		end
	end

	assign out_valid = v_s[NS-1];
	assign root      = q_s[NS-1];
	assign out_side  = side_s[NS-1];

endmodule

FILE: src/bpsd_div.sv
// Pipelined restoring divider, three lanes of |d|*2^30/dist, one quotient bit per stage.
// Depends on bpsd_pkg.
module bpsd_div import bpsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  dmag_t [2:0] mag,
	input  div_side_t   in_side,
	output logic        out_valid,
	output quo_t [2:0]  quo,
	output div_side_t   out_side
);
	localparam int NS = QW;
	localparam int RW = ROOTW + 1;

	logic [NS-1:0]          v_s;
	logic [2:0][RW-1:0]     r_s    [NS];
	quo_t [2:0]             q_s    [NS];
	div_side_t              side_s [NS];

	for (genvar j = 0; j < NS; j++) begin : g_stage
		logic [2:0][RW-1:0] r_i, r_o;
		quo_t [2:0]         q_i, q_o;
		div_side_t          side_i;
		logic               v_i;

		if (j == 0) begin : g_first
			// |d| never exceeds dist, so |d|/2 already lies below the divisor
			for (genvar k = 0; k < 3; k++) begin : g_init
				assign r_i[k] = {{(RW-DW+1){1'b0}}, mag[k][DW-1:1]};
			end
			assign q_i    = '0;
			assign side_i = in_side;
			assign v_i    = in_valid;
		end else begin : g_next
			assign r_i    = r_s[j-1];
			assign q_i    = q_s[j-1];
			assign side_i = side_s[j-1];
			assign v_i    = v_s[j-1];
		end

		for (genvar k = 0; k < 3; k++) begin : g_lane
			logic [RW-1:0] rr;
			logic          nb, ge;
			assign nb = (j == 0) ? mag[k][0] : 1'b0;
			assign rr = {r_i[k][RW-2:0], nb};
			assign ge = (rr >= {1'b0, side_i.sep_len});
			assign r_o[k] = ge ? rr - {1'b0, side_i.sep_len} : rr;
			assign q_o[k] = {q_i[k][QW-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[j] <= 1'b0;
			else if (en) v_s[j] <= v_i;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[j]    <= r_o;
				q_s[j]    <= q_o;
				side_s[j] <= side_i;
			end
		end
	end

	assign out_valid = v_s[NS-1];
	assign quo       = q_s[NS-1];
	assign out_side  = side_s[NS-1];

endmodule

FILE: src/bonded_pair_spring_damper_force_core.sv
// Top level of the bonded pair spring and dashpot force core.
// Depends on bpsd_pkg, bpsd_sqrt and bpsd_div.
//
// Usage: every word on the s_ stream is one bonded pair (positions and
// velocities of spheres i and j, signed Q16.16). Every word produces exactly
// one word on the m_ stream: the force on sphere i (three 48-bit Q32.16
// components, saturated) and in m_tuser the coincident flag, set with zero
// force when both centers are equal.
// Stiffness, damping and rest length are written over the APB port while
// the stream is idle; pready is tied high and reads return the register.
// Pipeline from input accept to output valid: 3 front stages, 34 square-root
// stages, 31 divider stages, 6 back stages ending in the output register.
// One word per clock while m_tready does not stall a valid output, set by the
// fully pipelined root and divide units, each resolving one bit per stage.
// Reset clears every valid bit and the three registers; no word is held.
// When m_tready is low with a valid output the whole pipeline holds in
// place and s_tready drops; nothing is lost or repeated.
module bonded_pair_spring_damper_force_core import bpsd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [383:0]  s_tdata,   // pos_i_x,y,z, pos_j_x,y,z, vel_i_x,y,z, vel_j_x,y,z
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [143:0]  m_tdata,   // force_x, force_y, force_z
	output logic [0:0]    m_tuser,   // coincident
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [AW-1:0] paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	logic en;
	logic [31:0] stiff_q, damp_q, rest_q;

	// ---------------- configuration registers ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_q <= '0;
			damp_q  <= '0;
			rest_q  <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr)
				ADDR_STIFF: stiff_q <= pwdata;
				ADDR_DAMP:  damp_q  <= pwdata;
				ADDR_REST:  rest_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			ADDR_STIFF: prdata = stiff_q;
			ADDR_DAMP:  prdata = damp_q;
			ADDR_REST:  prdata = rest_q;
			default:    prdata = '0;
		endcase
	end

	// advance every stage together unless the output word is stuck
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// ---------------- S1: differences ----------------
	logic                 v_s1;
	logic signed [DW-1:0] d_s1 [3];
	logic signed [DW-1:0] dv_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				d_s1[k]  <= $signed({s_tdata[96+32*k+31], s_tdata[96+32*k +: 32]})
				          - $signed({s_tdata[32*k+31], s_tdata[32*k +: 32]});
				dv_s1[k] <= $signed({s_tdata[288+32*k+31], s_tdata[288+32*k +: 32]})
				          - $signed({s_tdata[192+32*k+31], s_tdata[192+32*k +: 32]});
			end
		end
	end

	// ---------------- S2: squares ----------------
	logic        v_s2;
	dmag_t [2:0] mag_s2;
	logic  [2:0] neg_s2;
	rad_t        sq_s2 [3];
	logic signed [DW-1:0] dv_s2 [3];
	dmag_t [2:0] mag_c;

	always_comb begin
		for (int k = 0; k < 3; k++)
			mag_c[k] = d_s1[k][DW-1] ? dmag_t'(-d_s1[k]) : dmag_t'(d_s1[k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				mag_s2[k] <= mag_c[k];
				neg_s2[k] <= d_s1[k][DW-1];
				sq_s2[k]  <= RADW'(mag_c[k]) * RADW'(mag_c[k]);
				dv_s2[k]  <= dv_s1[k];
			end
		end
	end

	// ---------------- S3: squared distance ----------------
	logic       v_s3;
	rad_t       sum_s3;
	sqrt_side_t side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3         <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			side_s3.g.neg  <= neg_s2;
			side_s3.g.dv_x <= dv_s2[0];
			side_s3.g.dv_y <= dv_s2[1];
			side_s3.g.dv_z <= dv_s2[2];
			side_s3.g.zero <= (mag_s2 == '0);
			side_s3.mag    <= mag_s2;
		end
	end

	// ---------------- distance and normal ----------------
	logic       sq_v;
	root_t      dist_w;
	sqrt_side_t sq_side;
	div_side_t  dv_in_side, dv_side;
	logic       dq_v;
	quo_t [2:0] quo_w;

	bpsd_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.rad      (sum_s3),
		.in_side  (side_s3),
		.out_valid(sq_v),
		.root     (dist_w),
		.out_side (sq_side)
	);

	assign dv_in_side.g       = sq_side.g;
	assign dv_in_side.sep_len = dist_w;

	bpsd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sq_v),
		.mag      (sq_side.mag),
		.in_side  (dv_in_side),
		.out_valid(dq_v),
		.quo      (quo_w),
		.out_side (dv_side)
	);

	// ---------------- S4: normal speed products ----------------
	logic        v_s4;
	logic [63:0] vp_s4 [3];
	logic [2:0]  vneg_s4, nneg_s4;
	quo_t [2:0]  q_s4;
	root_t       dist_s4;
	logic        zero_s4;
	logic signed [DW-1:0] dvk [3];
	dmag_t       dvm [3];

	assign dvk[0] = dv_side.g.dv_x;
	assign dvk[1] = dv_side.g.dv_y;
	assign dvk[2] = dv_side.g.dv_z;

	always_comb begin
		for (int k = 0; k < 3; k++)
			dvm[k] = dvk[k][DW-1] ? dmag_t'(-dvk[k]) : dmag_t'(dvk[k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= dq_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				vp_s4[k]   <= 64'(quo_w[k]) * 64'(dvm[k]);
				vneg_s4[k] <= dv_side.g.neg[k] ^ dvk[k][DW-1];
			end
			nneg_s4 <= dv_side.g.neg;
			q_s4    <= quo_w;
			dist_s4 <= dv_side.sep_len;
			zero_s4 <= dv_side.g.zero;
		end
	end

	// ---------------- S5: normal speed and stretch ----------------
	logic               v_s5;
	logic signed [36:0] vn_s5;
	logic signed [35:0] delta_s5;
	logic [2:0]         nneg_s5;
	quo_t [2:0]         q_s5;
	logic               zero_s5;
	logic signed [36:0] vt [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			vt[k] = {3'b000, vp_s4[k][63:30]};
			if (vneg_s4[k]) vt[k] = -vt[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vn_s5    <= vt[0] + vt[1] + vt[2];
			delta_s5 <= $signed({2'b00, dist_s4}) - $signed({4'b0000, rest_q});
			nneg_s5  <= nneg_s4;
			q_s5     <= q_s4;
			zero_s5  <= zero_s4;
		end
	end

	// ---------------- S6: spring and dashpot products ----------------
	logic        v_s6;
	logic [66:0] ks_s6;
	logic [67:0] kd_s6;
	logic        kneg_s6, dneg_s6;
	logic [2:0]  nneg_s6;
	quo_t [2:0]  q_s6;
	logic        zero_s6;
	logic [34:0] dlm;
	logic [35:0] vnm;

	assign dlm = delta_s5[35] ? 35'(-delta_s5) : 35'(delta_s5);
	assign vnm = vn_s5[36] ? 36'(-vn_s5) : 36'(vn_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ks_s6   <= 67'(stiff_q) * 67'(dlm);
			kd_s6   <= 68'(damp_q) * 68'(vnm);
			kneg_s6 <= delta_s5[35];
			dneg_s6 <= vn_s5[36];
			nneg_s6 <= nneg_s5;
			q_s6    <= q_s5;
			zero_s6 <= zero_s5;
		end
	end

	// ---------------- S7: scalar force ----------------
	logic               v_s7;
	logic signed [52:0] s_s7;
	logic [2:0]         nneg_s7;
	quo_t [2:0]         q_s7;
	logic               zero_s7;
	logic signed [52:0] kst, kdt;

	always_comb begin
		kst = {2'b00, ks_s6[66:16]};
		kdt = {1'b0, kd_s6[67:16]};
		if (kneg_s6) kst = -kst;
		if (dneg_s6) kdt = -kdt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (en) v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s7    <= kst + kdt;
			nneg_s7 <= nneg_s6;
			q_s7    <= q_s6;
			zero_s7 <= zero_s6;
		end
	end

	// ---------------- S8: force partial products ----------------
	logic        v_s8;
	logic [62:0] pl_s8 [3];
	logic [50:0] ph_s8 [3];
	logic [2:0]  fneg_s8;
	logic        zero_s8;
	logic [51:0] smag;

	assign smag = s_s7[52] ? 52'(-s_s7) : 52'(s_s7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (en) v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				pl_s8[k]   <= 63'(smag[31:0]) * 63'(q_s7[k]);
				ph_s8[k]   <= 51'(smag[51:32]) * 51'(q_s7[k]);
				fneg_s8[k] <= s_s7[52] ^ nneg_s7[k];
			end
			zero_s8 <= zero_s7;
		end
	end

	// ---------------- S9: combine, saturate, output register ----------------
	logic        v_s9;
	logic [47:0] f_s9 [3];
	logic        coin_s9;
	logic [83:0] prod [3];
	logic [53:0] fm [3];
	logic [47:0] fo [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			prod[k] = {ph_s8[k], 32'h0} + 84'(pl_s8[k]);
			fm[k]   = prod[k][83:30];
			if (zero_s8)
				fo[k] = '0;
			else if (!fneg_s8[k])
				fo[k] = (fm[k][53:47] != '0) ? 48'h7FFF_FFFF_FFFF : fm[k][47:0];
			else
				fo[k] = (fm[k] > 54'h80_0000_0000_00) ? 48'h8000_0000_0000
				                                       : 48'(-fm[k][47:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (en) v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s9    <= fo;
			coin_s9 <= zero_s8;
		end
	end

	assign m_tvalid = v_s9;
	assign m_tdata  = {f_s9[2], f_s9[1], f_s9[0]};
	assign m_tuser  = coin_s9;

endmodule

FILE: src/bpsd_checker.sv
// Port-level checker of the bonded pair force core, bound to the top level.
// Depends on bonded_pair_spring_damper_force_core_defines.svh.
`include "bonded_pair_spring_damper_force_core_defines.svh"

module bpsd_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [143:0] m_tdata,
	input logic [0:0]   m_tuser,
	input logic         pready
);
	`BPSD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word dropped or changed while stalled")
	`BPSD_ASSERT_NOW(a_coin_zero, m_tvalid && m_tuser[0], m_tdata == '0, "coincident word carries nonzero force")
	`BPSD_ASSERT_NOW(a_ready_free, !m_tvalid, s_tready, "input blocked with empty output")
	`BPSD_ASSERT_NOW(a_stall_ready, m_tvalid && !m_tready, !s_tready, "input taken while pipeline holds")
	`BPSD_ASSERT_NOW(a_pready, 1'b1, pready, "pready dropped")
endmodule

bind bonded_pair_spring_damper_force_core bpsd_checker u_bpsd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.pready  (pready)
);
